// ===== hdl/kvt_pkg.sv =====
// kvt_pkg: transaction structs, operation and status codes for the
// key/value table. No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam logic [1:0] OP_PUT     = 2'd0;
  localparam logic [1:0] OP_GET     = 2'd1;
  localparam logic [1:0] OP_SET_ALL = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] value_in;
  } kvt_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic [1:0]  status;
  } kvt_out_t;

  // Control part of a request as it moves down the cell chain.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       found;    // some earlier cell held the key
    logic       claimed;  // some earlier cell took the new key
  } kvt_ctl_t;

endpackage

// ===== hdl/key_value_table_with_set_all_unit.sv =====
// key_value_table_with_set_all_unit: top level, a chain of kvt_cell slots
// with result formatting at the tail. Depends on kvt_pkg and kvt_cell.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (kvt_in_t)
//  out     | output    | out_valid / out_ready | out_data (kvt_out_t)
//
// Each transaction walks the cell chain one cell per cycle unless stalled,
// and one transaction enters per cycle while in_ready is high.
// The tail cell's stage is the output register. Stalls collapse bubbles:
// a stage advances when it or some stage ahead of it is empty, or when
// out_ready is high.
// Reset empties the table and the chain.
`timescale 1ns / 1ps

module key_value_table_with_set_all_unit import kvt_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kvt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output kvt_out_t out_data
);

  kvt_ctl_t              ctl   [ENTRIES+1];
  logic [KEY_BITS-1:0]   keys  [ENTRIES+1];
  logic [VALUE_BITS-1:0] vals  [ENTRIES+1];
  logic                  takes [ENTRIES+1];
  kvt_ctl_t              tail;
  logic [VALUE_BITS-1:0] tail_val;

  always_comb begin
    ctl[0].valid   = in_valid;
    ctl[0].op      = in_data.operation;
    ctl[0].found   = 1'b0;
    ctl[0].claimed = 1'b0;
  end
  assign keys[0]  = KEY_BITS'(in_data.key);
  assign vals[0]  = VALUE_BITS'(in_data.value_in);
  assign in_ready = takes[0];
  assign takes[ENTRIES] = out_ready;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .prev_ctl  (ctl[i]),
      .prev_key  (keys[i]),
      .prev_val  (vals[i]),
      .next_take (takes[i+1]),
      .take      (takes[i]),
      .ctl_r     (ctl[i+1]),
      .req_key_r (keys[i+1]),
      .req_val_r (vals[i+1])
    );
  end

  assign tail     = ctl[ENTRIES];
  assign tail_val = vals[ENTRIES];
  assign out_valid = tail.valid;

  always_comb begin
    out_data.found     = 1'b0;
    out_data.value_out = '0;
    out_data.status    = ST_OK;
    case (tail.op)
      OP_PUT: begin
        out_data.found = tail.found;
        if (!tail.found && !tail.claimed) begin
          out_data.status = ST_FULL;
        end
      end
      OP_GET: begin
        out_data.found = tail.found;
        if (tail.found) begin
          out_data.value_out = 32'(tail_val);
        end else begin
          out_data.status = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/kvt_cell.sv =====
// kvt_cell: one table slot plus one stage of the request chain.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_cell import kvt_pkg::*; #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kvt_ctl_t              prev_ctl,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_val,
  input  logic                  next_take,
  output logic                  take,
  output kvt_ctl_t              ctl_r,
  output logic [KEY_BITS-1:0]   req_key_r,
  output logic [VALUE_BITS-1:0] req_val_r
);

  logic                  used_r;
  logic                  used_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   key_nxt;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;
  kvt_ctl_t              ctl_nxt;
  logic [VALUE_BITS-1:0] req_val_nxt;
  logic                  hit;

  // Stage is free when empty or when its transaction moves on this cycle.
  assign take = !ctl_r.valid || next_take;
  assign hit  = used_r && (key_r == prev_key);

  always_comb begin
    used_nxt    = used_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    ctl_nxt     = prev_ctl;
    req_val_nxt = prev_val;
    if (prev_ctl.valid) begin
      case (prev_ctl.op)
        OP_PUT: begin
          if (hit && !prev_ctl.found) begin
            val_nxt       = prev_val;
            ctl_nxt.found = 1'b1;
          end else if (!used_r && !prev_ctl.found && !prev_ctl.claimed) begin
            used_nxt        = 1'b1;
            key_nxt         = prev_key;
            val_nxt         = prev_val;
            ctl_nxt.claimed = 1'b1;
          end
        end
        OP_GET: begin
          // value lane carries the read data from here on
          if (hit && !prev_ctl.found) begin
            ctl_nxt.found = 1'b1;
            req_val_nxt   = val_r;
          end
        end
        OP_SET_ALL: begin
          if (used_r) begin
            val_nxt = prev_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      ctl_r.valid <= 1'b0;
    end else if (take) begin
      used_r <= used_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r     <= key_nxt;
      val_r     <= val_nxt;
      req_key_r <= prev_key;
      req_val_r <= req_val_nxt;
    end
  end

endmodule

// ===== bench/tb_key_value_table_with_set_all_unit.sv =====
// tb_key_value_table_with_set_all_unit: self-checking bench for the key/value table,
// with directed and random put/get/set-all traffic checked against a local table model.
// Depends on kvt_pkg and key_value_table_with_set_all_unit.
`timescale 1ns / 1ps

module tb_key_value_table_with_set_all_unit;
  import kvt_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int  HALF_PERIOD  = 6;
  localparam int  RESET_CYCLES = 6;
  localparam int  MAX_IDLE     = 9;
  localparam int  HOLD_CYCLES  = 80;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  kvt_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  kvt_out_t out_data;

  key_value_table_with_set_all_unit #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Local copy of the table contents
  logic [31:0] stored_keys   [ENTRIES];
  logic [31:0] stored_values [ENTRIES];
  int          stored_count;

  kvt_out_t    pending_results[$];
  logic [31:0] key_pool[$];
  int          error_count;
  bit          sender_idle_on;
  bit          receiver_idle_on;
  bit          receiver_hold_request;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Updates the local table for one request and returns its result
  function automatic kvt_out_t apply_request(input kvt_in_t req);
    kvt_out_t res;
    int       slot;
    int       i;
    res  = '0;
    slot = -1;
    for (i = 0; i < stored_count; i++) begin
      if (slot < 0 && stored_keys[i] == req.key) slot = i;
    end
    case (req.operation)
      OP_PUT: begin
        if (slot >= 0) begin
          stored_values[slot] = req.value_in;
          res.found = 1'b1;
        end else if (stored_count < ENTRIES) begin
          stored_keys[stored_count]   = req.key;
          stored_values[stored_count] = req.value_in;
          stored_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_GET: begin
        if (slot >= 0) begin
          res.found     = 1'b1;
          res.value_out = stored_values[slot];
        end else begin
          res.status = ST_MISSING;
        end
      end
      OP_SET_ALL: begin
        for (i = 0; i < stored_count; i++) stored_values[i] = req.value_in;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] pick_stored_key();
    if (stored_count == 0) return $urandom();
    return stored_keys[$urandom_range(0, stored_count - 1)];
  endfunction

  function automatic logic [31:0] pick_known_key();
    if (key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return pick_stored_key();
  endfunction

  // fresh_put_pct: share of puts that use a never-seen key
  function automatic kvt_in_t make_request(input int fresh_put_pct);
    kvt_in_t req;
    int      roll;
    int      key_roll;
    roll         = $urandom_range(0, 99);
    key_roll     = $urandom_range(0, 99);
    req.key      = $urandom();
    req.value_in = $urandom();
    if (roll < 42) begin
      req.operation = OP_PUT;
      if (key_roll >= fresh_put_pct) req.key = pick_known_key();
    end else if (roll < 82) begin
      req.operation = OP_GET;
      if (key_roll < 40) req.key = pick_known_key();
      else if (key_roll < 75) req.key = pick_stored_key();
    end else if (roll < 94) begin
      req.operation = OP_SET_ALL;
    end else begin
      req.operation = OP_UNUSED;
    end
    return req;
  endfunction

  // Called and returns at a falling edge; valid is left high after the transaction
  task automatic send_request(input kvt_in_t req);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(req));
    @(negedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [31:0] key,
                         input logic [31:0] value);
    kvt_in_t req;
    req.operation = op;
    req.key       = key;
    req.value_in  = value;
    send_request(req);
  endtask

  // Sender pause until every outstanding result is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    send_op(OP_GET,     32'h0000_0000, 32'hFFFF_FFFF);  // empty table
    send_op(OP_SET_ALL, 32'hFFFF_FFFF, 32'h0000_0005);  // set-all with nothing stored
    send_op(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_PUT,     32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_PUT,     32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_GET,     32'h0000_0000, 32'h0000_0000);
    send_op(OP_GET,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_PUT,     32'h0000_0000, 32'h1234_5678);  // overwrite
    send_op(OP_GET,     32'h0000_0000, 32'h0000_0000);
    send_op(OP_SET_ALL, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_PUT,     32'hA5A5_A5A5, 32'h0000_0001);  // new key after set-all
    send_op(OP_GET,     32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_GET,     32'hA5A5_A5A5, 32'h0000_0000);
    send_op(OP_SET_ALL, 32'hA5A5_A5A5, 32'h0000_0000);
    send_op(OP_GET,     32'hA5A5_A5A5, 32'hFFFF_FFFF);
    send_op(OP_UNUSED,  32'h0000_0000, 32'h0000_0000);
    send_op(OP_GET,     32'h5A5A_5A5A, 32'h5A5A_5A5A);  // absent key
    wait_for_drain();
  endtask

  // Puts stay within a small key pool, so most of them hit stored keys
  task automatic test_random_partial_table(input int count, input bit idle_on);
    int n;
    sender_idle_on   = idle_on;
    receiver_idle_on = idle_on;
    key_pool.delete();
    for (n = 0; n < 10; n++) key_pool.push_back($urandom());
    for (n = 0; n < count; n++) send_request(make_request(0));
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    int n;
    sender_idle_on        = 1'b0;
    receiver_idle_on      = 1'b0;
    receiver_hold_request = 1'b1;
    for (n = 0; n < 40; n++) send_request(make_request(0));
    wait_for_drain();
  endtask

  // Fresh keys fill the table, after which new-key puts are dropped
  task automatic test_random_full_table(input int count);
    int n;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    key_pool.delete();
    for (n = 0; n < count; n++) begin
      if (n == count / 2) receiver_idle_on = 1'b0;
      send_request(make_request(40));
    end
    wait_for_drain();
  endtask

  // Result check
  always @(posedge clk) begin
    kvt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", 32'(out_data.found), 32'(want.found));
        if (out_data.value_out !== want.value_out)
          report_mismatch("value_out", out_data.value_out, want.value_out);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  // Result side flow control: random stalls plus an occasional long hold-off
  initial begin
    int  stall_left;
    int  hold_left;
    bit  taken;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      taken = out_valid && out_ready;
      @(negedge clk);
      if (taken) stall_left = receiver_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (receiver_hold_request) begin
        receiver_hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_data               = '0;
    error_count           = 0;
    stored_count          = 0;
    sender_idle_on        = 1'b1;
    receiver_idle_on      = 1'b1;
    receiver_hold_request = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_partial_table(400, 1'b1);
    test_random_partial_table(300, 1'b0);
    test_backpressure();
    test_random_full_table(1150);

    // Let any stray result show up
    repeat (2 * ENTRIES + 4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
